/* rtl/pfcr_pkg.sv */
// ----------------------------------------------------------------------------
// pfcr_pkg
// Shared types and constants for the per-flow congestion rate controller.
// ----------------------------------------------------------------------------
package pfcr_pkg;

	localparam int FLOWS      = 64;
	localparam int RATE_BITS  = 40;
	localparam int FLOW_W     = 6;
	localparam int FUNC_W     = 3;
	localparam int TIME_W     = 48;
	localparam int FACT_W     = 17;
	localparam int IVL_W      = 24;
	localparam int MODE_W     = 2;
	localparam int Q_BITS     = 16;
	localparam int PROD_W     = RATE_BITS + FACT_W;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 40;

	localparam logic [FUNC_W-1:0] FN_INIT  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_CNP   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_BECN  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CHECK = 3'd3;
	localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

	localparam logic [MODE_W-1:0] MODE_STEADY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SLOW   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AGGR   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CNP_FACTOR  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BECN_FACTOR = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_STEP   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AGGR_FACTOR = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RECOV_IVL   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CNP_MIN_IVL = 4'd7;

	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [FLOW_W-1:0]    flow;
		logic [RATE_BITS-1:0] rate_bps;
		logic [TIME_W-1:0]    now_ns;
	} cmd_t;

	typedef struct packed {
		logic                 flow_known;
		logic [RATE_BITS-1:0] current_rate;
		logic [MODE_W-1:0]    mode;
		logic                 rate_changed;
		logic                 recovery_armed;
		logic                 notice_ignored;
	} res_t;

	typedef struct packed {
		logic [RATE_BITS-1:0] min_rate;
		logic [FACT_W-1:0]    cnp_factor;
		logic [FACT_W-1:0]    becn_factor;
		logic [RATE_BITS-1:0] slow_step;
		logic [FACT_W-1:0]    aggressive_factor;
		logic [FACT_W-1:0]    threshold_fraction;
		logic [IVL_W-1:0]     recovery_interval;
		logic [IVL_W-1:0]     cnp_min_interval;
	} cfg_regs_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic mul;
		logic wb;
	} ctrl_cmd_t;

endpackage

/* rtl/pfcr_cfg.sv */
// ----------------------------------------------------------------------------
// pfcr_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module pfcr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pfcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfcr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output pfcr_pkg::cfg_regs_t              regs
);
	import pfcr_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_rate           <= RATE_BITS'(100_000_000);
			regs_q.cnp_factor         <= FACT_W'(65536);
			regs_q.becn_factor        <= FACT_W'(32768);
			regs_q.slow_step          <= RATE_BITS'(100_000_000);
			regs_q.aggressive_factor  <= FACT_W'(6554);
			regs_q.threshold_fraction <= FACT_W'(32768);
			regs_q.recovery_interval  <= IVL_W'(50000);
			regs_q.cnp_min_interval   <= IVL_W'(10000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_RATE:    regs_q.min_rate           <= cfg_data[RATE_BITS-1:0];
				REG_CNP_FACTOR:  regs_q.cnp_factor         <= cfg_data[FACT_W-1:0];
				REG_BECN_FACTOR: regs_q.becn_factor        <= cfg_data[FACT_W-1:0];
				REG_SLOW_STEP:   regs_q.slow_step          <= cfg_data[RATE_BITS-1:0];
				REG_AGGR_FACTOR: regs_q.aggressive_factor  <= cfg_data[FACT_W-1:0];
				REG_THRESHOLD:   regs_q.threshold_fraction <= cfg_data[FACT_W-1:0];
				REG_RECOV_IVL:   regs_q.recovery_interval  <= cfg_data[IVL_W-1:0];
				REG_CNP_MIN_IVL: regs_q.cnp_min_interval   <= cfg_data[IVL_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/pfcr_ctrl.sv */
// ----------------------------------------------------------------------------
// pfcr_ctrl
// Sequencer: read, prepare operands, multiply, write back.
// ----------------------------------------------------------------------------
module pfcr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output pfcr_pkg::ctrl_cmd_t   ctl
);
	import pfcr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_WB   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_PREP;
			ST_PREP: state_d = ST_MUL;
			ST_MUL:  state_d = ST_WB;
			ST_WB:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign ctl.load = (state_q == ST_IDLE) && start;
	assign ctl.prep = (state_q == ST_PREP);
	assign ctl.mul  = (state_q == ST_MUL);
	assign ctl.wb   = (state_q == ST_WB);

endmodule

/* rtl/pfcr_dp.sv */
// ----------------------------------------------------------------------------
// pfcr_dp
// Flow table and rate arithmetic: one read-modify-write per command.
// ----------------------------------------------------------------------------
module pfcr_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfcr_pkg::ctrl_cmd_t   ctl,
	input  pfcr_pkg::cfg_regs_t   cfg,
	input  pfcr_pkg::cmd_t        cmd,
	output pfcr_pkg::res_t        res,
	output logic                  done
);
	import pfcr_pkg::*;

	typedef struct packed {
		logic [RATE_BITS-1:0] line;
		logic [RATE_BITS-1:0] rate;
		logic [MODE_W-1:0]    mode;
		logic                 seen;
		logic [TIME_W-1:0]    last_t;
		logic [TIME_W-1:0]    due;
		logic                 pending;
	} flow_rec_t;

	flow_rec_t            mem_q [FLOWS];
	logic [FLOWS-1:0]     valid_q;

	cmd_t                 in_q;
	flow_rec_t            rd_q;
	logic                 known_q;
	logic                 ign_q;
	logic                 due_ok_q;
	logic [RATE_BITS-1:0] sum_q;
	logic [TIME_W-1:0]    nd_q;
	logic [RATE_BITS-1:0] op_a_q;
	logic [FACT_W-1:0]    op_b_q;
	logic [PROD_W-1:0]    prod_q;
	res_t                 res_q;
	logic                 done_q;

	// operand preparation
	logic                 flow_ok;
	logic [TIME_W-1:0]    since;
	logic                 ign;
	logic                 due_ok;
	logic [RATE_BITS:0]   sum_w;
	logic [RATE_BITS-1:0] gap;
	logic [TIME_W-1:0]    base_t;
	logic [TIME_W:0]      tsum;
	logic [RATE_BITS-1:0] op_a;
	logic [FACT_W-1:0]    op_b;

	assign flow_ok = (32'(cmd.flow) < FLOWS);

	always_comb begin
		since  = in_q.now_ns - rd_q.last_t;
		ign    = rd_q.seen && ((in_q.now_ns < rd_q.last_t) ||
		         (since < TIME_W'(cfg.cnp_min_interval)));
		due_ok = rd_q.pending && (in_q.now_ns >= rd_q.due);
		sum_w  = {1'b0, rd_q.rate} + {1'b0, cfg.slow_step};
		gap    = (rd_q.line > rd_q.rate) ? (rd_q.line - rd_q.rate) : '0;
		base_t = (in_q.func == FN_CNP) ? in_q.now_ns : rd_q.due;
		tsum   = {1'b0, base_t} + {1'b0, TIME_W'(cfg.recovery_interval)};
		priority if (in_q.func == FN_CNP) begin
			op_a = in_q.rate_bps;
			op_b = cfg.cnp_factor;
		end else if (in_q.func == FN_BECN) begin
			op_a = rd_q.rate;
			op_b = cfg.becn_factor;
		end else if (rd_q.mode == MODE_SLOW) begin
			op_a = rd_q.line;
			op_b = cfg.threshold_fraction;
		end else begin
			op_a = gap;
			op_b = cfg.aggressive_factor;
		end
	end

	// write back
	logic [RATE_BITS:0]   scaled;
	logic [RATE_BITS-1:0] mq;
	logic [RATE_BITS-1:0] floored;
	logic [RATE_BITS:0]   ag_w;
	logic [RATE_BITS-1:0] ag;
	logic [RATE_BITS-1:0] step_r;
	flow_rec_t            nrec;
	logic                 changed;
	logic                 ignored;
	logic                 wr_en;

	always_comb begin
		scaled  = prod_q[PROD_W-1:Q_BITS];
		mq      = scaled[RATE_BITS] ? '1 : scaled[RATE_BITS-1:0];
		floored = (mq < cfg.min_rate) ? cfg.min_rate : mq;
		ag_w    = {1'b0, rd_q.rate} + {1'b0, mq};
		ag      = ag_w[RATE_BITS] ? '1 : ag_w[RATE_BITS-1:0];
		step_r  = (rd_q.mode == MODE_SLOW) ? sum_q : ag;
		nrec    = rd_q;
		changed = 1'b0;
		ignored = 1'b0;
		wr_en   = 1'b0;
		unique case (in_q.func)
			FN_INIT: begin
				nrec.line    = in_q.rate_bps;
				nrec.rate    = in_q.rate_bps;
				nrec.mode    = MODE_STEADY;
				nrec.seen    = 1'b0;
				nrec.last_t  = '0;
				nrec.due     = '0;
				nrec.pending = 1'b0;
				changed      = 1'b1;
				wr_en        = 1'b1;
			end
			FN_CNP: begin
				if (ign_q) begin
					ignored = 1'b1;
				end else begin
					nrec.seen    = 1'b1;
					nrec.last_t  = in_q.now_ns;
					nrec.rate    = floored;
					nrec.mode    = MODE_SLOW;
					nrec.due     = nd_q;
					nrec.pending = 1'b1;
					changed      = 1'b1;
					wr_en        = 1'b1;
				end
			end
			FN_BECN: begin
				nrec.rate = floored;
				nrec.mode = MODE_STEADY;
				changed   = 1'b1;
				wr_en     = 1'b1;
			end
			FN_CHECK: begin
				if (due_ok_q) begin
					wr_en        = 1'b1;
					nrec.pending = 1'b0;
					if (rd_q.mode != MODE_STEADY) begin
						changed = 1'b1;
						if (rd_q.mode == MODE_SLOW && sum_q > mq) begin
							nrec.mode = MODE_AGGR;
						end
						if (step_r >= rd_q.line) begin
							nrec.rate = rd_q.line;
							nrec.mode = MODE_STEADY;
						end else begin
							nrec.rate    = step_r;
							nrec.due     = nd_q;
							nrec.pending = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			in_q    <= cmd;
			rd_q    <= mem_q[cmd.flow];
		end
		if (ctl.prep) begin
			ign_q    <= ign;
			due_ok_q <= due_ok;
			sum_q    <= sum_w[RATE_BITS] ? '1 : sum_w[RATE_BITS-1:0];
			nd_q     <= tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
			op_a_q   <= op_a;
			op_b_q   <= op_b;
		end
		if (ctl.mul) begin
			prod_q <= PROD_W'(op_a_q) * PROD_W'(op_b_q);
		end
		if (ctl.wb) begin
			if (known_q) begin
				res_q <= '{flow_known: 1'b1, current_rate: nrec.rate, mode: nrec.mode,
				           rate_changed: changed, recovery_armed: nrec.pending,
				           notice_ignored: ignored};
			end else begin
				res_q <= '{flow_known: 1'b0, current_rate: cfg.min_rate,
				           mode: MODE_STEADY, rate_changed: 1'b0,
				           recovery_armed: 1'b0, notice_ignored: 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wb && known_q && wr_en) begin
			mem_q[in_q.flow] <= nrec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			known_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.wb;
			if (ctl.load) begin
				known_q <= flow_ok && ((cmd.func == FN_INIT) || valid_q[cmd.flow]);
			end
			if (ctl.wb && known_q && (in_q.func == FN_INIT)) begin
				valid_q[in_q.flow] <= 1'b1;
			end
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

/* rtl/per_flow_congestion_rate_control.sv */
// ----------------------------------------------------------------------------
// per_flow_congestion_rate_control
// Per-flow rate controller: CNP/BECN decrease, timed slow and aggressive
// recovery toward line rate, at most one flow table entry updated per command.
//
//  channel  | handshake             | beat
//  ---------+-----------------------+-------------------------------------
//  command  | start / busy          | cmd  (func, flow, rate_bps, now_ns)
//  result   | done (1-cycle strobe) | res  (flow_known .. notice_ignored)
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Steps per command: table read, operand prep, multiply, write back; a new
// command is taken in the cycle its result is shown. The single table
// read-modify-write keeps commands apart. The result is registered after
// write back. Reset clears all flows to unknown and loads the register
// defaults; no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module per_flow_congestion_rate_control (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  pfcr_pkg::cmd_t                   cmd,
	output logic                             done,
	output pfcr_pkg::res_t                   res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pfcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pfcr_pkg::*;

	cfg_regs_t regs;
	ctrl_cmd_t ctl;

	pfcr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	pfcr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	pfcr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (regs),
		.cmd    (cmd),
		.res    (res),
		.done   (done)
	);

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result not delivered four cycles after command");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_unknown_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.flow_known) |-> (res.mode == MODE_STEADY && !res.rate_changed &&
		 !res.recovery_armed && !res.notice_ignored))
		else $error("unknown flow result carries flow state");

	a_ignored_nochange: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.notice_ignored) |-> !res.rate_changed)
		else $error("ignored notice changed the rate");
`endif

endmodule
